// File: src/nbs_pkg.sv
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared types, codes and helpers of the naive Bayes spam scorer.
// ----------------------------------------------------------------------------
package nbs_pkg;

   // log unit operand width: covers the sum of 256 32-bit counts plus the count
   localparam int LOG_IN_W   = 42;
   localparam int LOG_P_W    = 6;
   localparam int LOG_FRAC_W = 24;
   localparam int LOG2_W     = LOG_P_W + LOG_FRAC_W;
   localparam logic [31:0] LOG10_2_Q32 = 32'h4D104D42;

   localparam int CNT_W     = 9;
   localparam int SUM_W     = 40;
   localparam int ACC_W     = 42;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TOKEN    = 2'd1,
      OP_CLASSIFY = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HAM_MSG  = 3'd0,
      CSR_SPAM_MSG = 3'd1,
      CSR_MARGIN   = 3'd2,
      CSR_NORM     = 3'd3,
      CSR_TOP_K    = 3'd4,
      CSR_ATTR_CNT = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TOKEN,
      ST_PRIOR_S,
      ST_PRIOR_H,
      ST_SUM,
      ST_T_RD,
      ST_T_WAIT,
      ST_T_LOGH,
      ST_T_LOGS,
      ST_T_DIVH,
      ST_T_DIVS,
      ST_T_WR,
      ST_K_SCAN,
      ST_K_PICK,
      ST_ACC,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_NORM,
      L_SQR,
      L_MUL,
      L_RND
   } log_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  entry_index;
      logic [30:0] attribute_id;
      logic [31:0] ham_count;
      logic [31:0] spam_count;
      logic [30:0] token_id;
   } req_type;

   typedef struct packed {
      logic               is_spam;
      logic signed [31:0] spam_score;
      logic signed [31:0] ham_score;
   } rsp_type;

   typedef struct packed {
      logic [30:0] id;
      logic [31:0] ham;
      logic [31:0] spam;
   } entry_type;

   typedef struct packed {
      logic signed [31:0] ham;
      logic signed [31:0] spam;
   } term_type;

   typedef struct packed {
      logic                start;
      logic [LOG_IN_W-1:0] num;
      logic [LOG_IN_W-1:0] den;
   } log_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] value;
   } log_rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] term;
      logic [32:0]        norm;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] value;
   } div_rsp_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage

// File: src/nbs_log10.sv
// ----------------------------------------------------------------------------
// nbs_log10
// Iterative log10(num/den) in signed fixed point, via log2 in Q.24.
// ----------------------------------------------------------------------------
module nbs_log10 #(
   parameter int FRAC = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  nbs_pkg::log_req_type lreq,
   output nbs_pkg::log_rsp_type lrsp
);
   import nbs_pkg::*;

   localparam int SH     = 56 - FRAC;
   localparam int PROD_W = LOG2_W + 32;
   localparam int RND_W  = PROD_W + 1;

   log_state_type state_ff, state_in;
   logic [LOG_IN_W-1:0]   x_ff, x_in, den_ff, den_in;
   logic [LOG_P_W-1:0]    p_ff, p_in;
   logic [31:0]           m_ff, m_in;
   logic [LOG_FRAC_W-1:0] frac_ff, frac_in;
   logic [4:0]            step_ff, step_in;
   logic                  sel_ff, sel_in;
   logic [LOG2_W-1:0]     lg_num_ff, lg_num_in;
   logic signed [LOG2_W:0] d_ff, d_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   logic signed [31:0]    val_ff, val_in;

   logic [63:0]           sq;
   logic [32:0]           sq_t;
   logic [LOG_FRAC_W-1:0] frac_nx;
   logic [LOG2_W-1:0]     lg_cur;
   logic [LOG2_W:0]       d_neg;
   logic [LOG2_W-1:0]     d_mag;
   logic [RND_W-1:0]      rnd;
   logic [RND_W-SH-1:0]   r;
   logic [31:0]           r32;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff      <= x_in;
      den_ff    <= den_in;
      p_ff      <= p_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      step_ff   <= step_in;
      sel_ff    <= sel_in;
      lg_num_ff <= lg_num_in;
      d_ff      <= d_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      val_ff    <= val_in;
   end

   always_comb begin
      sq      = m_ff * m_ff;
      sq_t    = sq[63:31];
      frac_nx = {frac_ff[LOG_FRAC_W-2:0], sq_t[32]};
      lg_cur  = {p_ff, frac_nx};
      d_neg   = -d_ff;
      d_mag   = d_ff[LOG2_W] ? d_neg[LOG2_W-1:0] : d_ff[LOG2_W-1:0];
      rnd     = {1'b0, prod_ff} + (RND_W'(1) << (SH - 1));
      r       = rnd[RND_W-1:SH];
      r32     = 32'(r);

      state_in  = state_ff;
      x_in      = x_ff;
      den_in    = den_ff;
      p_in      = p_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      step_in   = step_ff;
      sel_in    = sel_ff;
      lg_num_in = lg_num_ff;
      d_in      = d_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      val_in    = val_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         L_IDLE: begin
            if (lreq.start) begin
               if (lreq.num == '0 || lreq.den == '0) begin
                  val_in  = 32'sh8000_0000;
                  done_in = 1'b1;
               end else begin
                  x_in     = lreq.num;
                  den_in   = lreq.den;
                  p_in     = LOG_P_W'(LOG_IN_W - 1);
                  sel_in   = 1'b0;
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            // one bit per cycle until the msb reaches the top
            if (x_ff[LOG_IN_W-1]) begin
               m_in     = x_ff[LOG_IN_W-1 -: 32];
               frac_in  = '0;
               step_in  = '0;
               state_in = L_SQR;
            end else begin
               x_in = x_ff << 1;
               p_in = p_ff - LOG_P_W'(1);
            end
         end
         L_SQR: begin
            m_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_in = frac_nx;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(LOG_FRAC_W - 1)) begin
               if (!sel_ff) begin
                  lg_num_in = lg_cur;
                  x_in      = den_ff;
                  p_in      = LOG_P_W'(LOG_IN_W - 1);
                  sel_in    = 1'b1;
                  state_in  = L_NORM;
               end else begin
                  d_in     = $signed({1'b0, lg_num_ff}) - $signed({1'b0, lg_cur});
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            prod_in  = d_mag * LOG10_2_Q32;
            neg_in   = d_ff[LOG2_W];
            state_in = L_RND;
         end
         L_RND: begin
            if (neg_ff) val_in = $signed(~r32 + 32'd1);
            else        val_in = r32[31] ? 32'sh7FFF_FFFF : $signed(r32);
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   assign lrsp.done  = done_ff;
   assign lrsp.value = val_ff;

endmodule

// File: src/nbs_div.sv
// ----------------------------------------------------------------------------
// nbs_div
// Bit-serial rounded divide of a term by the pair's magnitude sum.
// ----------------------------------------------------------------------------
module nbs_div #(
   parameter int FRAC = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  nbs_pkg::div_req_type dreq,
   output nbs_pkg::div_rsp_type drsp
);
   import nbs_pkg::*;

   localparam int DW = FRAC + 34;
   localparam int VW = 34;
   localparam int CW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DW-1:0]   num_ff, num_in, q_ff, q_in;
   logic [VW-1:0]   rem_ff, rem_in, v_ff, v_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            neg_ff, neg_in;
   logic signed [31:0] val_ff, val_in;

   logic [VW:0]     rem_sh;
   logic            qbit;
   logic [32:0]     qc;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      v_ff   <= v_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      val_ff <= val_in;
   end

   always_comb begin
      rem_sh = {rem_ff, num_ff[DW-1]};
      qbit   = rem_sh >= {1'b0, v_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      v_in    = v_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      val_in  = val_ff;
      qc      = '0;
      if (!busy_ff) begin
         if (dreq.start) begin
            // (2n + s) / (2s) gives the half-up rounding
            num_in  = (DW'(mag32(dreq.term)) << (FRAC + 1)) + DW'(dreq.norm);
            v_in    = {dreq.norm, 1'b0};
            rem_in  = '0;
            q_in    = '0;
            cnt_in  = CW'(DW);
            neg_in  = dreq.term[31];
            busy_in = 1'b1;
         end
      end else begin
         rem_in = qbit ? VW'(rem_sh - {1'b0, v_ff}) : rem_sh[VW-1:0];
         num_in = num_ff << 1;
         q_in   = {q_ff[DW-2:0], qbit};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            qc = (|q_in[DW-1:32]) ? 33'h1_0000_0000 : {1'b0, q_in[31:0]};
            if (neg_ff) val_in = qc[32] || qc[31] ? 32'sh8000_0000
                                                   : $signed(~qc[31:0] + 32'd1);
            else        val_in = qc[32] || qc[31] ? 32'sh7FFF_FFFF : $signed(qc[31:0]);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   assign drsp.done  = done_ff;
   assign drsp.value = val_ff;

endmodule

// File: src/naive_bayes_spam_scorer.sv
// ----------------------------------------------------------------------------
// naive_bayes_spam_scorer
// Attribute table, token marking and naive Bayes classify over two memories.
// ----------------------------------------------------------------------------
//  channel   ports                                  transfer
//  request   start, busy, req_data                  start && !busy
//  result    rsp_valid, rsp_data                    one-cycle strobe
//  config    csr_valid, csr_ready, csr_index/wdata  valid && ready
//
// Load: one entry memory write. Token: entry memory scan, first match wins.
// Classify: two log calls for the priors and a scan for the count sums, then per
// entry a zero term pair when absent or two log calls (and two divides when
// normalizing a nonzero pair) when present, then a scratch scan per top-k round
// and one to sum. Log unit: normalize and squaring loop; bit-serial divider. Sync reset; no clearing pass.
// The result strobe cannot be stalled; busy stays high while a transaction runs.
module naive_bayes_spam_scorer #(
   parameter int MAX_ENTRIES     = 256,
   parameter int SCORE_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  nbs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output nbs_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);
   import nbs_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   // configuration
   logic [31:0]        ham_msg_ff, spam_msg_ff;
   logic signed [31:0] margin_ff;
   logic               norm_ff;
   logic [CNT_W-1:0]   topk_ff, attr_ff;
   logic [CNT_W-1:0]   m_cnt;

   // memories
   entry_type ent_mem [MAX_ENTRIES];
   term_type  scr_mem [MAX_ENTRIES];
   entry_type ent_q;
   term_type  scr_q;
   logic      ent_we, ent_re, scr_we, scr_re;
   logic [AW-1:0] ent_raddr, scr_addr;
   term_type  scr_wdata;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [30:0]        tok_ff, tok_in;
   logic [MAX_ENTRIES-1:0] present_ff, present_in, sel_ff, sel_in;
   logic signed [31:0] prior_s_ff, prior_s_in, prior_h_ff, prior_h_in;
   logic [SUM_W-1:0]   nh_ff, nh_in, ns_ff, ns_in;
   logic signed [31:0] th_ff, th_in, ts_ff, ts_in;
   logic [32:0]        norm_s_ff, norm_s_in;
   logic [31:0]        best_ff, best_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]   round_ff, round_in;
   logic signed [ACC_W-1:0] sum_s_ff, sum_s_in, sum_h_ff, sum_h_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   log_req_type lreq;
   log_rsp_type lrsp;
   div_req_type dreq;
   div_rsp_type drsp;

   logic        scan_issue, scan_end;
   logic [31:0] ah, as_m;
   logic [32:0] pair_s;
   logic signed [31:0] ps, ph;
   logic signed [33:0] diff;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > $signed(ACC_W'(32'h7FFF_FFFF)))      return 32'sh7FFF_FFFF;
      else if (v < -$signed(ACC_W'(33'h0_8000_0000))) return 32'sh8000_0000;
      else                                          return 32'(v);
   endfunction

   nbs_log10 #(.FRAC(SCORE_FRAC_BITS)) u_log (
      .clock (clock), .reset (reset), .lreq (lreq), .lrsp (lrsp));

   nbs_div #(.FRAC(SCORE_FRAC_BITS)) u_div (
      .clock (clock), .reset (reset), .dreq (dreq), .drsp (drsp));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ham_msg_ff  <= 32'd1;
         spam_msg_ff <= 32'd1;
         margin_ff   <= '0;
         norm_ff     <= 1'b0;
         topk_ff     <= '0;
         attr_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HAM_MSG:  ham_msg_ff  <= csr_wdata;
            CSR_SPAM_MSG: spam_msg_ff <= csr_wdata;
            CSR_MARGIN:   margin_ff   <= $signed(csr_wdata);
            CSR_NORM:     norm_ff     <= csr_wdata[0];
            CSR_TOP_K:    topk_ff     <= csr_wdata[CNT_W-1:0];
            CSR_ATTR_CNT: attr_ff     <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign m_cnt = (32'(attr_ff) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : attr_ff;

   // entry table and term scratch
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[AW'(req_data.entry_index)] <= {req_data.attribute_id,
                                                        req_data.ham_count,
                                                        req_data.spam_count};
      if (ent_re) ent_q <= ent_mem[ent_raddr];
      if (scr_we) scr_mem[scr_addr] <= scr_wdata;
      if (scr_re) scr_q <= scr_mem[scr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         present_ff   <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         present_ff   <= present_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      tok_ff      <= tok_in;
      prior_s_ff  <= prior_s_in;
      prior_h_ff  <= prior_h_in;
      nh_ff       <= nh_in;
      ns_ff       <= ns_in;
      th_ff       <= th_in;
      ts_ff       <= ts_in;
      norm_s_ff   <= norm_s_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      ptr_ff      <= ptr_in;
      round_ff    <= round_in;
      sum_s_ff    <= sum_s_in;
      sum_h_ff    <= sum_h_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      scan_issue = scan_cnt_ff < m_cnt;
      scan_end   = !scan_issue && !rd_vld_ff;
      ah         = mag32(scr_q.ham);
      as_m       = mag32(scr_q.spam);
      pair_s     = {1'b0, mag32(th_ff)} + {1'b0, mag32(lrsp.value)};
      ps         = sat32(sum_s_ff);
      ph         = sat32(sum_h_ff);
      diff       = 34'(ps) - 34'(ph);

      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = AW'(scan_cnt_ff);
      tok_in       = tok_ff;
      present_in   = present_ff;
      sel_in       = sel_ff;
      prior_s_in   = prior_s_ff;
      prior_h_in   = prior_h_ff;
      nh_in        = nh_ff;
      ns_in        = ns_ff;
      th_in        = th_ff;
      ts_in        = ts_ff;
      norm_s_in    = norm_s_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      ptr_in       = ptr_ff;
      round_in     = round_ff;
      sum_s_in     = sum_s_ff;
      sum_h_in     = sum_h_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      ent_we    = 1'b0;
      ent_re    = 1'b0;
      ent_raddr = AW'(scan_cnt_ff);
      scr_we    = 1'b0;
      scr_re    = 1'b0;
      scr_addr  = AW'(scan_cnt_ff);
      scr_wdata = {th_ff, ts_ff};

      lreq.start = 1'b0;
      lreq.num   = LOG_IN_W'(ent_q.ham) + LOG_IN_W'(1);
      lreq.den   = LOG_IN_W'(nh_ff) + LOG_IN_W'(m_cnt);
      dreq.start = 1'b0;
      dreq.term  = th_ff;
      dreq.norm  = norm_s_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.op)
                  OP_LOAD: ent_we = 32'(req_data.entry_index) < MAX_ENTRIES;
                  OP_TOKEN: begin
                     tok_in      = req_data.token_id;
                     scan_cnt_in = '0;
                     state_in    = ST_TOKEN;
                  end
                  OP_CLASSIFY: begin
                     lreq.start = 1'b1;
                     lreq.num   = LOG_IN_W'(spam_msg_ff);
                     lreq.den   = LOG_IN_W'(ham_msg_ff) + LOG_IN_W'(spam_msg_ff);
                     state_in   = ST_PRIOR_S;
                  end
                  default: ;
               endcase
            end
         end
         ST_TOKEN: begin
            ent_re = scan_issue;
            if (scan_issue) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            rd_vld_in = scan_issue;
            if (rd_vld_ff && ent_q.id == tok_ff) begin
               present_in[rd_idx_ff] = 1'b1;
               state_in = ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_PRIOR_S: begin
            if (lrsp.done) begin
               prior_s_in = lrsp.value;
               lreq.start = 1'b1;
               lreq.num   = LOG_IN_W'(ham_msg_ff);
               lreq.den   = LOG_IN_W'(ham_msg_ff) + LOG_IN_W'(spam_msg_ff);
               state_in   = ST_PRIOR_H;
            end
         end
         ST_PRIOR_H: begin
            if (lrsp.done) begin
               prior_h_in  = lrsp.value;
               scan_cnt_in = '0;
               nh_in       = '0;
               ns_in       = '0;
               sel_in      = '0;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            ent_re = scan_issue;
            if (scan_issue) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            rd_vld_in = scan_issue;
            if (rd_vld_ff) begin
               nh_in = nh_ff + SUM_W'(ent_q.ham);
               ns_in = ns_ff + SUM_W'(ent_q.spam);
            end
            if (scan_end) begin
               scan_cnt_in = '0;
               state_in    = ST_T_RD;
            end
         end
         ST_T_RD: begin
            if (scan_cnt_ff == m_cnt) begin
               scan_cnt_in = '0;
               best_in     = '0;
               found_in    = 1'b0;
               round_in    = '0;
               sum_s_in    = ACC_W'(prior_s_ff);
               sum_h_in    = ACC_W'(prior_h_ff);
               state_in    = (topk_ff == '0) ? ST_ACC : ST_K_SCAN;
            end else begin
               ent_re   = 1'b1;
               state_in = ST_T_WAIT;
            end
         end
         ST_T_WAIT: begin
            if (!present_ff[AW'(scan_cnt_ff)]) begin
               th_in    = '0;
               ts_in    = '0;
               state_in = ST_T_WR;
            end else begin
               lreq.start = 1'b1;
               state_in   = ST_T_LOGH;
            end
         end
         ST_T_LOGH: begin
            lreq.num = LOG_IN_W'(ent_q.spam) + LOG_IN_W'(1);
            lreq.den = LOG_IN_W'(ns_ff) + LOG_IN_W'(m_cnt);
            if (lrsp.done) begin
               th_in      = lrsp.value;
               lreq.start = 1'b1;
               state_in   = ST_T_LOGS;
            end
         end
         ST_T_LOGS: begin
            if (lrsp.done) begin
               ts_in = lrsp.value;
               if (!norm_ff) begin
                  state_in = ST_T_WR;
               end else if (pair_s == '0) begin
                  th_in    = '0;
                  ts_in    = '0;
                  state_in = ST_T_WR;
               end else begin
                  norm_s_in  = pair_s;
                  dreq.start = 1'b1;
                  dreq.norm  = pair_s;
                  state_in   = ST_T_DIVH;
               end
            end
         end
         ST_T_DIVH: begin
            if (drsp.done) begin
               th_in      = drsp.value;
               dreq.start = 1'b1;
               dreq.term  = ts_ff;
               state_in   = ST_T_DIVS;
            end
         end
         ST_T_DIVS: begin
            if (drsp.done) begin
               ts_in    = drsp.value;
               state_in = ST_T_WR;
            end
         end
         ST_T_WR: begin
            scr_we      = 1'b1;
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            state_in    = ST_T_RD;
         end
         ST_K_SCAN: begin
            scr_re = scan_issue;
            if (scan_issue) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            rd_vld_in = scan_issue;
            // ">=" keeps the later entry on ties
            if (rd_vld_ff && !sel_ff[rd_idx_ff] && (ah >= best_ff || as_m >= best_ff)) begin
               found_in = 1'b1;
               ptr_in   = rd_idx_ff;
               best_in  = (ah > as_m) ? ah : as_m;
            end
            if (scan_end) state_in = ST_K_PICK;
         end
         ST_K_PICK: begin
            scan_cnt_in = '0;
            best_in     = '0;
            found_in    = 1'b0;
            if (!found_ff) begin
               state_in = ST_ACC;
            end else begin
               sel_in[ptr_ff] = 1'b1;
               round_in = round_ff + CNT_W'(1);
               state_in = ({1'b0, round_ff} + 10'd1 == {1'b0, topk_ff}) ? ST_ACC : ST_K_SCAN;
            end
         end
         ST_ACC: begin
            scr_re = scan_issue;
            if (scan_issue) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            rd_vld_in = scan_issue;
            if (rd_vld_ff && (topk_ff == '0 || sel_ff[rd_idx_ff])) begin
               sum_s_in = sum_s_ff + ACC_W'(scr_q.spam);
               sum_h_in = sum_h_ff + ACC_W'(scr_q.ham);
            end
            if (scan_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in.is_spam    = diff > 34'(margin_ff);
            rsp_in.spam_score = ps;
            rsp_in.ham_score  = ph;
            rsp_valid_in      = 1'b1;
            present_in        = '0;
            state_in          = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a classify in flight");

   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_CLASSIFY) |=> busy)
      else $error("classify accepted but block not busy");

   a_load_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_LOAD) |=> (!busy && !rsp_valid))
      else $error("load must complete in one cycle without a result");

   a_present_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (present_ff == '0))
      else $error("present flags not cleared by classify");

endmodule
